// File: rtl/hsv2rgb_pkg.sv
// Package: types, constants and helper functions for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W        = 13;
    localparam int LEVEL_W      = 8;
    localparam int SECTOR_W     = 4;
    localparam int REM_W        = 10;
    localparam int PROD_W       = 2 * LEVEL_W;

    typedef logic [HUE_W-1:0]    hue_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [SECTOR_W-1:0] sector_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [PROD_W-1:0]   prod_t;

    // 60 degrees in 1/16 degree steps
    localparam hue_t SECTOR_STEPS = hue_t'(960);
    localparam int   NUM_THRESH   = 8;

    localparam level_t FULL_LEVEL = level_t'(255);

    // 1/15 scaled by 2^19, exact for all x < 3840
    localparam int        RECIP15_W     = 16;
    localparam int        RECIP15_SHIFT = 19;
    localparam logic [RECIP15_W-1:0] RECIP15 = 16'd34953;

    // Sector codes, hue / 960
    localparam sector_t SECTOR_RED_YEL  = sector_t'(0);
    localparam sector_t SECTOR_YEL_GRN  = sector_t'(1);
    localparam sector_t SECTOR_GRN_CYN  = sector_t'(2);
    localparam sector_t SECTOR_CYN_BLU  = sector_t'(3);
    localparam sector_t SECTOR_BLU_MAG  = sector_t'(4);

    // floor(y / 255), exact for y < 65280
    function automatic level_t div255(input prod_t y);
        logic [PROD_W:0] tmp;
        tmp = {1'b0, y} + {9'd0, y[PROD_W-1:LEVEL_W]} + 17'd1;
        return tmp[PROD_W-1:LEVEL_W];
    endfunction

    // Start of sector k in hue steps
    function automatic hue_t sector_base(input sector_t k);
        logic [HUE_W+SECTOR_W-1:0] tmp;
        tmp = {{HUE_W{1'b0}}, k} * {{SECTOR_W{1'b0}}, SECTOR_STEPS};
        return tmp[HUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_core.sv
// HSV to RGB converter: five-stage pipelined datapath with valid/ready channels.
`default_nettype none

// Converts one HSV color per request into 8-bit red, green and blue. Hue is in
// 1/16 degree steps (0..5759), saturation and brightness are 8-bit fractions
// of one. Hue codes 5760..8191 fall into the last sector's color mapping.
// Throughput is one request per clock when the output is not stalled. out_valid
// rises once a request has passed through every register stage. The pipeline
// has five register stages:
//   1. sector = hue / 960 by threshold compares, remainder within sector
//   2. f = remainder * 256 / 960 by reciprocal multiply; v * (255 - s)
//   3. s * f and s * (256 - f), giving the q and t scale factors
//   4. v times both scale factors
//   5. divide by 255, sector permutation, output register
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stalled output still lets new requests in
// until every stage is full. Zero saturation needs no special case: p, q and
// t all reduce to brightness. No configuration and no state beyond the pipe.
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [HUE_W-1:0]   hue,
    input  wire logic [LEVEL_W-1:0] saturation,
    input  wire logic [LEVEL_W-1:0] brightness,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [LEVEL_W-1:0]      red,
    output logic [LEVEL_W-1:0]      green,
    output logic [LEVEL_W-1:0]      blue
);

    // ---------------- stage advance chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !v5_reg || out_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign in_ready  = adv1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: sector split ----------------
    sector_t sector_next;
    rem_t    rem_next;
    hue_t    rem_full;

    always_comb
    begin
        sector_next = '0;
        for (int k = 1; k <= NUM_THRESH; k++)
        begin
            if (hue >= sector_base(sector_t'(k)))
                sector_next = sector_t'(k);
        end
        rem_full = hue - sector_base(sector_next);
        rem_next = rem_full[REM_W-1:0];
    end

    sector_t s1_sector_reg;
    rem_t    rem_reg;
    level_t  s1_sat_reg, s1_val_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_sector_reg <= sector_next;
            rem_reg       <= rem_next;
            s1_sat_reg    <= saturation;
            s1_val_reg    <= brightness;
        end
    end

    // ---------------- stage 2: fraction and p product ----------------
    localparam int X_W    = REM_W + 2;
    localparam int FPROD_W = X_W + RECIP15_W;

    logic [X_W-1:0]     x4;
    logic [FPROD_W-1:0] fprod;
    level_t             f_next;
    prod_t              pprod_next;

    always_comb
    begin
        x4         = {rem_reg, 2'b00};
        fprod      = {{RECIP15_W{1'b0}}, x4} * {{X_W{1'b0}}, RECIP15};
        f_next     = fprod[RECIP15_SHIFT+LEVEL_W-1:RECIP15_SHIFT];
        pprod_next = prod_t'(s1_val_reg) * prod_t'(FULL_LEVEL - s1_sat_reg);
    end

    sector_t s2_sector_reg;
    level_t  s2_sat_reg, s2_val_reg, f_reg;
    prod_t   s2_pprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_sat_reg    <= s1_sat_reg;
            s2_val_reg    <= s1_val_reg;
            f_reg         <= f_next;
            s2_pprod_reg  <= pprod_next;
        end
    end

    // ---------------- stage 3: q and t scale factors ----------------
    logic [LEVEL_W:0]    f_comp;
    logic [PROD_W:0]     sf_prod, sg_prod;
    level_t              kq_next, kt_next;

    always_comb
    begin
        f_comp  = (LEVEL_W+1)'(256) - {1'b0, f_reg};
        sf_prod = {1'b0, {LEVEL_W{1'b0}}, s2_sat_reg} * {{LEVEL_W{1'b0}}, 1'b0, f_reg};
        sg_prod = {1'b0, {LEVEL_W{1'b0}}, s2_sat_reg} * {{LEVEL_W{1'b0}}, f_comp};
        kq_next = FULL_LEVEL - sf_prod[PROD_W-1:LEVEL_W];
        kt_next = FULL_LEVEL - sg_prod[PROD_W-1:LEVEL_W];
    end

    sector_t s3_sector_reg;
    level_t  s3_val_reg, kq_reg, kt_reg;
    prod_t   s3_pprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            kq_reg        <= kq_next;
            kt_reg        <= kt_next;
            s3_pprod_reg  <= s2_pprod_reg;
        end
    end

    // ---------------- stage 4: v times q and t factors ----------------
    sector_t s4_sector_reg;
    level_t  s4_val_reg;
    prod_t   s4_pprod_reg, qprod_reg, tprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
            s4_pprod_reg  <= s3_pprod_reg;
            qprod_reg     <= prod_t'(s3_val_reg) * prod_t'(kq_reg);
            tprod_reg     <= prod_t'(s3_val_reg) * prod_t'(kt_reg);
        end
    end

    // ---------------- stage 5: scale down and permute ----------------
    level_t p_lvl, q_lvl, t_lvl;
    level_t red_next, green_next, blue_next;

    always_comb
    begin
        p_lvl = div255(s4_pprod_reg);
        q_lvl = div255(qprod_reg);
        t_lvl = div255(tprod_reg);
        case (s4_sector_reg)
            SECTOR_RED_YEL:
            begin
                red_next = s4_val_reg; green_next = t_lvl; blue_next = p_lvl;
            end
            SECTOR_YEL_GRN:
            begin
                red_next = q_lvl; green_next = s4_val_reg; blue_next = p_lvl;
            end
            SECTOR_GRN_CYN:
            begin
                red_next = p_lvl; green_next = s4_val_reg; blue_next = t_lvl;
            end
            SECTOR_CYN_BLU:
            begin
                red_next = p_lvl; green_next = q_lvl; blue_next = s4_val_reg;
            end
            SECTOR_BLU_MAG:
            begin
                red_next = t_lvl; green_next = p_lvl; blue_next = s4_val_reg;
            end
            default:
            begin
                // last sector and out-of-range hue
                red_next = s4_val_reg; green_next = p_lvl; blue_next = q_lvl;
            end
        endcase
    end

    level_t red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

`ifndef SYNTHESIS
    // back-pressure reaches the input only once every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("input stalled while pipeline has a bubble");

    // sector split leaves a remainder inside one sector
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (rem_reg < SECTOR_STEPS[REM_W-1:0]))
        else $error("sector remainder out of range");

    // an accepted request lands in stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted request lost at stage one");

    // a stalled stage four request is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && v5_reg && !out_ready) |=> v4_reg)
        else $error("stage four request dropped under stall");
`endif

endmodule

`default_nettype wire
